FILE: src/deq_pkg.sv
// deque package: sizes, request codes, controller states, command/status types and index wrap helpers
`default_nettype none
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int HELD_W   = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = 5;
  localparam int REQ_W    = 2;
  localparam int OUT_W    = 2 * VALUE_W + ENTRY_W + 3;
  localparam int OUT_PAD  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: src/double_ended_queue_core.sv
// deque core top level: 16-entry circular buffer of signed 32-bit values
// a beat is accepted, its entries are read through the registered ram, then its result beat is loaded
// only one request is in flight: s_tready stays low from accept until the result load
// the result load waits while the previous output beat is still held
// rst (synchronous, active high) empties the queue and clears both indices
// entry ram contents are not cleared; values of unwritten entries never reach the output
`default_nettype none
module double_ended_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [deq_pkg::VALUE_W-1:0]       s_tdata,  // push_value
  input  logic [deq_pkg::REQ_W-1:0]         s_tuser,  // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // front_value, back_value, entry_count, is_empty, is_full, op_error, zero pad to whole bytes (none at 72 bits)
  output logic [deq_pkg::OUT_PAD-1:0]       m_tdata
);
  import deq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (s_tuser),
    .push_value (s_tdata),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

FILE: src/deq_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

FILE: src/deq_ctrl.sv
// deque controller: sequences accept, entry read and result load
`default_nettype none
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded while output beat still pending");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.rd_en)
    else $error("entry read did not follow accepted beat");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("second beat taken while one is in flight");

endmodule
`default_nettype wire

FILE: src/deq_datapath.sv
// deque datapath: indices, count, entry ram and output register
`default_nettype none
module deq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::cmd_t                   cmd,
  output deq_pkg::sts_t                   sts,
  input  logic [deq_pkg::REQ_W-1:0]       req_type,
  input  logic [deq_pkg::VALUE_W-1:0]     push_value,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [deq_pkg::OUT_PAD-1:0]     m_tdata
);
  import deq_pkg::*;

  logic [IDX_W-1:0]   front_index;
  logic [IDX_W-1:0]   back_index;
  logic [HELD_W-1:0]  held_count;
  logic               op_error;
  logic [IDX_W-1:0]   front_index_next;
  logic [IDX_W-1:0]   back_index_next;
  logic [HELD_W-1:0]  held_count_next;
  logic               op_error_next;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               full;
  logic               empty;
  logic [VALUE_W-1:0] rd_front;
  logic [VALUE_W-1:0] rd_back;
  logic [VALUE_W-1:0] front_value;
  logic [VALUE_W-1:0] back_value;
  logic [OUT_W-1:0]   out_beat;
  req_t               req;

  assign req     = req_t'(req_type);
  assign full    = (held_count == HELD_W'(CAPACITY));
  assign empty   = (held_count == '0);

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    held_count_next  = held_count;
    op_error_next    = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = front_index;
    unique case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          op_error_next = 1'b1;
        end else begin
          wr_en           = 1'b1;
          held_count_next = held_count + HELD_W'(1);
          if (empty) begin
            back_index_next = front_index;
            wr_addr         = front_index;
          end else if (req == REQ_PUSH_FRONT) begin
            front_index_next = wrap_dec(front_index);
            wr_addr          = wrap_dec(front_index);
          end else begin
            back_index_next = wrap_inc(back_index);
            wr_addr         = wrap_inc(back_index);
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) begin
          op_error_next = 1'b1;
        end else begin
          held_count_next = held_count - HELD_W'(1);
          if (held_count != HELD_W'(1)) begin
            if (req == REQ_POP_FRONT) front_index_next = wrap_inc(front_index);
            else back_index_next = wrap_dec(back_index);
          end
        end
      end
      default: begin
        op_error_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      held_count  <= '0;
      op_error    <= 1'b0;
    end else if (cmd.accept) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      held_count  <= held_count_next;
      op_error    <= op_error_next;
    end
  end

  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk       (clk),
    .wr_en     (cmd.accept && wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (push_value),
    .rd_en     (cmd.rd_en),
    .rd_addr_a (front_index),
    .rd_addr_b (back_index),
    .rd_data_a (rd_front),
    .rd_data_b (rd_back)
  );

  assign front_value = empty ? '1 : rd_front;
  assign back_value  = empty ? '1 : rd_back;
  assign out_beat    = {op_error, full, empty, ENTRY_W'(held_count), back_value, front_value};

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= OUT_PAD'(out_beat);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HELD_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && op_error_next) |=>
      ($stable(held_count) && $stable(front_index) && $stable(back_index)))
    else $error("dropped request changed queue state");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2*VALUE_W+ENTRY_W] == (m_tdata[2*VALUE_W +: ENTRY_W] == '0)))
    else $error("empty flag disagrees with entry count");

endmodule
`default_nettype wire
